### src/pcelc_pkg.sv
// Package with shared types, codes and the length-load table of the pulse control block.
`timescale 1ns / 1ps
package pcelc_pkg;

  // Default spacing of frame ticks.
  localparam int unsigned FRAME_PERIOD_DEF = 7457;

  // The frame divider point is one bit wider than a timestamp.
  localparam int unsigned FP_W = 17;

  // Item function codes.
  localparam logic [1:0] FUNC_WRITE     = 2'd0;
  localparam logic [1:0] FUNC_FRAME_END = 2'd1;
  localparam logic [1:0] FUNC_SYNC      = 2'd2;

  // Register addresses.
  localparam logic [4:0] REG_ENV_A = 5'd0;
  localparam logic [4:0] REG_LO_A  = 5'd2;
  localparam logic [4:0] REG_HI_A  = 5'd3;
  localparam logic [4:0] REG_ENV_B = 5'd4;
  localparam logic [4:0] REG_LO_B  = 5'd6;
  localparam logic [4:0] REG_HI_B  = 5'd7;
  localparam logic [4:0] REG_PCM   = 5'd17;
  localparam logic [4:0] REG_EN    = 5'd21;

  // Envelope and length state of one channel.
  typedef struct packed {
    logic [3:0] env_period;
    logic [3:0] env_divider;
    logic [3:0] env_level;
    logic [1:0] env_mode;
    logic       env_reload;
    logic [7:0] len_count;
  } chan_t;

  // Volume follows the constant-volume flag in mode bit 0.
  function automatic logic [3:0] vol_of(chan_t c);
    vol_of = c.env_mode[0] ? c.env_period : c.env_level;
  endfunction

  // Length-load table, indexed by the upper five bits of the high-period byte.
  function automatic logic [7:0] len_load(logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'h0A;
      5'd1:  v = 8'hFE;
      5'd2:  v = 8'h14;
      5'd3:  v = 8'h02;
      5'd4:  v = 8'h28;
      5'd5:  v = 8'h04;
      5'd6:  v = 8'h50;
      5'd7:  v = 8'h06;
      5'd8:  v = 8'hA0;
      5'd9:  v = 8'h08;
      5'd10: v = 8'h3C;
      5'd11: v = 8'h0A;
      5'd12: v = 8'h0E;
      5'd13: v = 8'h0C;
      5'd14: v = 8'h1A;
      5'd15: v = 8'h0E;
      5'd16: v = 8'h0C;
      5'd17: v = 8'h10;
      5'd18: v = 8'h18;
      5'd19: v = 8'h12;
      5'd20: v = 8'h30;
      5'd21: v = 8'h14;
      5'd22: v = 8'h60;
      5'd23: v = 8'h16;
      5'd24: v = 8'hC0;
      5'd25: v = 8'h18;
      5'd26: v = 8'h48;
      5'd27: v = 8'h1A;
      5'd28: v = 8'h10;
      5'd29: v = 8'h1C;
      5'd30: v = 8'h20;
      default: v = 8'h1E;
    endcase
    len_load = v;
  endfunction

endpackage

### src/pcelc_tick.sv
// Shared frame-tick unit: clocks the envelope and length counter of one channel.
`timescale 1ns / 1ps
module pcelc_tick (
  input  pcelc_pkg::chan_t cur_i,
  output pcelc_pkg::chan_t nxt_o
);
  import pcelc_pkg::*;

  // Envelope divider and level, then the length counter.
  always_comb begin
    nxt_o = cur_i;
    if (cur_i.env_reload) begin
      nxt_o.env_level   = 4'hF;
      nxt_o.env_divider = cur_i.env_period;
      nxt_o.env_reload  = 1'b0;
    end else if (cur_i.env_divider == 4'd0) begin
      nxt_o.env_divider = cur_i.env_period;
      // The level wraps from zero to fifteen only in loop mode.
      if (cur_i.env_level != 4'd0 || cur_i.env_mode[1]) begin
        nxt_o.env_level = cur_i.env_level - 4'd1;
      end
    end else begin
      nxt_o.env_divider = cur_i.env_divider - 4'd1;
    end
    if (!cur_i.env_mode[1] && cur_i.len_count != 8'd0) begin
      nxt_o.len_count = cur_i.len_count - 8'd1;
    end
  end

endmodule

### src/pulse_channel_envelope_length_control.sv
// Top level of the two-channel pulse envelope, length counter and register control block.
`timescale 1ns / 1ps
// Each input word is a time-stamped register write, a frame-end mark or a sync no-op.
// Before the word is applied, every frame tick whose divider point the timestamp has
// reached is clocked; the point advances by FRAME_PERIOD and FRAME_PERIOD + 1 in turn.
// One shared tick unit clocks channel A in the check state and channel B in the tick-B
// state for each tick that a word causes (at most about nine at the default period). A
// new word is taken once the done state has moved the result into an output register,
// so the next input word is taken while the previous result still waits downstream.
module pulse_channel_envelope_length_control #(
  parameter int unsigned FRAME_PERIOD = pcelc_pkg::FRAME_PERIOD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] timestamp_i,
  input  logic [4:0]  reg_addr_i,
  input  logic [7:0]  wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  volume_a_o,
  output logic [3:0]  volume_b_o,
  output logic [7:0]  length_a_o,
  output logic [7:0]  length_b_o,
  output logic [10:0] period_a_o,
  output logic [10:0] period_b_o,
  output logic [1:0]  duty_a_o,
  output logic [1:0]  duty_b_o,
  output logic [7:0]  pcm_level_o,
  output logic [3:0]  ticks_done_o
);
  import pcelc_pkg::*;

  localparam logic [FP_W-1:0] FP_STEP = FP_W'(FRAME_PERIOD);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_TICK_B,
    S_DONE
  } state_e;

  state_e          state_q;
  logic [FP_W-1:0] fp_q;
  logic            odd_q;
  chan_t           ch_q [2];
  logic [10:0]     period_q [2];
  logic [1:0]      duty_q [2];
  logic [1:0]      len_en_q;
  logic [7:0]      pcm_q;
  logic [3:0]      ticks_q;

  // Latched input word.
  logic [1:0]  func_q;
  logic [15:0] ts_q;
  logic [4:0]  addr_q;
  logic [7:0]  data_q;

  // Output register.
  logic        out_valid_q;
  logic [3:0]  vol_a_q, vol_b_q;
  logic [7:0]  len_a_q, len_b_q;
  logic [10:0] per_a_q, per_b_q;
  logic [1:0]  duty_a_q, duty_b_q;
  logic [7:0]  pcm_out_q;
  logic [3:0]  ticks_out_q;

  chan_t tick_cur;
  chan_t tick_nxt;
  logic  tick_due;
  logic  wch;

  // The tick unit serves channel A in the check state and channel B after it.
  assign tick_cur = (state_q == S_TICK_B) ? ch_q[1] : ch_q[0];
  assign tick_due = {1'b0, ts_q} >= fp_q;
  assign wch      = addr_q[2];

  pcelc_tick u_tick (
    .cur_i(tick_cur),
    .nxt_o(tick_nxt)
  );

  // Sequencer, channel state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fp_q        <= FP_STEP;
      odd_q       <= 1'b0;
      ch_q[0]     <= '0;
      ch_q[1]     <= '0;
      period_q[0] <= '0;
      period_q[1] <= '0;
      duty_q[0]   <= '0;
      duty_q[1]   <= '0;
      len_en_q    <= '0;
      pcm_q       <= '0;
      ticks_q     <= '0;
      func_q      <= '0;
      ts_q        <= '0;
      addr_q      <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
      vol_a_q     <= '0;
      vol_b_q     <= '0;
      len_a_q     <= '0;
      len_b_q     <= '0;
      per_a_q     <= '0;
      per_b_q     <= '0;
      duty_a_q    <= '0;
      duty_b_q    <= '0;
      pcm_out_q   <= '0;
      ticks_out_q <= '0;
    end else begin
      // The done state sets the valid flag itself when it hands a word over.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            ts_q    <= timestamp_i;
            addr_q  <= reg_addr_i;
            data_q  <= wdata_i;
            ticks_q <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (tick_due) begin
            ch_q[0] <= tick_nxt;
            state_q <= S_TICK_B;
          end else begin
            // No tick left: apply the word itself.
            if (func_q == FUNC_WRITE) begin
              case (addr_q)
                REG_ENV_A, REG_ENV_B: begin
                  ch_q[wch].env_period <= data_q[3:0];
                  ch_q[wch].env_mode   <= data_q[5:4];
                  duty_q[wch]          <= data_q[7:6];
                end
                REG_LO_A, REG_LO_B: begin
                  period_q[wch][7:0] <= data_q;
                end
                REG_HI_A, REG_HI_B: begin
                  period_q[wch][10:8]  <= data_q[2:0];
                  ch_q[wch].env_reload <= 1'b1;
                  if (len_en_q[wch]) begin
                    ch_q[wch].len_count <= len_load(data_q[7:3]);
                  end
                end
                REG_PCM: begin
                  if (data_q != 8'd0) begin
                    pcm_q <= data_q;
                  end
                end
                REG_EN: begin
                  if (!data_q[0]) begin
                    ch_q[0].len_count <= '0;
                  end
                  if (!data_q[1]) begin
                    ch_q[1].len_count <= '0;
                  end
                  len_en_q <= data_q[1:0];
                end
                default: begin
                end
              endcase
            end else if (func_q == FUNC_FRAME_END) begin
              fp_q <= fp_q - {1'b0, ts_q};
            end
            state_q <= S_DONE;
          end
        end
        S_TICK_B: begin
          ch_q[1] <= tick_nxt;
          fp_q    <= fp_q + FP_STEP + {{(FP_W-1){1'b0}}, odd_q};
          odd_q   <= ~odd_q;
          if (ticks_q != 4'hF) begin
            ticks_q <= ticks_q + 4'd1;
          end
          state_q <= S_CHECK;
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (!out_valid_q || !out_stall_i) begin
            vol_a_q     <= vol_of(ch_q[0]);
            vol_b_q     <= vol_of(ch_q[1]);
            len_a_q     <= ch_q[0].len_count;
            len_b_q     <= ch_q[1].len_count;
            per_a_q     <= period_q[0];
            per_b_q     <= period_q[1];
            duty_a_q    <= duty_q[0];
            duty_b_q    <= duty_q[1];
            pcm_out_q   <= pcm_q;
            ticks_out_q <= ticks_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign volume_a_o   = vol_a_q;
  assign volume_b_o   = vol_b_q;
  assign length_a_o   = len_a_q;
  assign length_b_o   = len_b_q;
  assign period_a_o   = per_a_q;
  assign period_b_o   = per_b_q;
  assign duty_a_o     = duty_a_q;
  assign duty_b_o     = duty_b_q;
  assign pcm_level_o  = pcm_out_q;
  assign ticks_done_o = ticks_out_q;

endmodule
